/* sv/menc_pkg.sv */
// Shared types, sizes and codes for the mesh edge numbering block.
// No dependencies; every other file but menc_ram imports this package.
package menc_pkg;

	localparam int MAX_TRIS    = 4096;
	localparam int MAX_EDGES   = 8192;
	localparam int KEY_SLOTS   = 16384;
	localparam int VERTEX_BITS = 16;

	localparam int TRI_W   = $clog2(MAX_TRIS);
	localparam int TCNT_W  = TRI_W + 1;
	localparam int EDGE_W  = $clog2(MAX_EDGES);
	localparam int ECNT_W  = EDGE_W + 1;
	localparam int SLOT_W  = $clog2(KEY_SLOTS);

	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam logic [31:0] HASH_C_LO  = HASH_MULT[31:0];
	localparam logic [SLOT_W-1:0] HASH_C_MID = HASH_MULT[32 +: SLOT_W];
	localparam logic [SLOT_W-1:0] HASH_C_BOT = HASH_MULT[0 +: SLOT_W];

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_FINISH = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_e;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] vertex_a;
		logic [15:0] vertex_b;
		logic [15:0] vertex_c;
		logic [12:0] edge_index;
	} in_item_t;

	typedef struct packed {
		logic [12:0] edge_id;
		logic        reversed;
		logic        last;
		logic [15:0] node_low;
		logic [15:0] node_high;
		logic [11:0] tri_left;
		logic [11:0] tri_right;
		logic        has_right;
		logic [12:0] dof_index;
		logic        has_dof;
		logic [13:0] count;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic                   used;
		logic [VERTEX_BITS-1:0] lo;
		logic [VERTEX_BITS-1:0] hi;
		logic [EDGE_W-1:0]      edge_id;
	} slot_t;

	typedef struct packed {
		logic [VERTEX_BITS-1:0] node_lo;
		logic [VERTEX_BITS-1:0] node_hi;
		logic [TRI_W-1:0]       tri_l;
		logic [TRI_W-1:0]       tri_r;
		logic                   right_set;
		logic [EDGE_W-1:0]      dof_num;
		logic                   dof_set;
	} edge_rec_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		slot_t             wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} slot_port_t;

	typedef struct packed {
		logic              we;
		logic [EDGE_W-1:0] waddr;
		edge_rec_t         wdata;
		logic              re;
		logic [EDGE_W-1:0] raddr;
	} edge_port_t;

endpackage

/* sv/menc_if.sv */
// Valid/ready channel interfaces for input items and results.
// Depends on menc_pkg for the payload types.
interface menc_in_if import menc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface menc_out_if import menc_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/menc_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependency.
module menc_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* sv/menc_hash.sv */
// Two-stage multiplicative hash of an undirected edge key into a slot index.
// Depends on menc_pkg for the multiplier constants and widths.
module menc_hash import menc_pkg::*; (
	input  logic                   clk,
	input  logic [VERTEX_BITS-1:0] lo,
	input  logic [VERTEX_BITS-1:0] hi,
	output logic [SLOT_W-1:0]      hash
);
	logic [VERTEX_BITS+31:0]     p_lo_s1;
	logic [SLOT_W-1:0]           p_mid_s1;
	logic [SLOT_W-1:0]           p_bot_s1;

	// key = lo:hi with lo at bit 32; only product bits 32 to 32+SLOT_W-1 are kept
	always_ff @(posedge clk) begin
		p_lo_s1  <= (VERTEX_BITS+32)'(hi) * (VERTEX_BITS+32)'(HASH_C_LO);
		p_mid_s1 <= SLOT_W'(hi * HASH_C_MID);
		p_bot_s1 <= SLOT_W'(lo * HASH_C_BOT);
		hash     <= SLOT_W'(p_lo_s1 >> 32) + p_mid_s1 + p_bot_s1;
	end
endmodule

/* sv/menc_ctrl.sv */
// Sequencer: slot table clear, probing, edge record updates, DOF walk, queries.
// Depends on menc_pkg, menc_if; drives both RAMs and the hash unit.
module menc_ctrl import menc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	menc_in_if.sink                in_ch,
	menc_out_if.source             out_ch,
	output logic [VERTEX_BITS-1:0] key_lo,
	output logic [VERTEX_BITS-1:0] key_hi,
	input  logic [SLOT_W-1:0]      hash,
	output slot_port_t             s_port,
	input  slot_t                  s_rdata,
	output edge_port_t             e_port,
	input  edge_rec_t              e_rdata
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_KEY, S_HASH1, S_HASH2, S_HASH3, S_PROBE, S_PCHK,
		S_ERD, S_FIN_RD, S_FIN_WR, S_QRD, S_QWAIT, S_EMIT
	} state_t;

	state_t                 state_q;
	logic                   elim_q;
	logic [TCNT_W-1:0]      tri_cnt_q;
	logic [ECNT_W-1:0]      edge_cnt_q;
	logic [SLOT_W-1:0]      clr_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      probe_q;
	logic [ECNT_W-1:0]      walk_q;
	logic [ECNT_W-1:0]      dof_cnt_q;
	logic [1:0]             k_q;
	logic                   more_q;
	logic [TRI_W-1:0]       tri_q;
	logic [EDGE_W-1:0]      id_q;
	logic                   rev_q;
	logic [VERTEX_BITS-1:0] lo_q;
	logic [VERTEX_BITS-1:0] hi_q;
	in_item_t               item_q;
	res_t                   res_q;
	res_t                   out_q;
	logic                   out_valid_q;

	logic [VERTEX_BITS-1:0] va;
	logic [VERTEX_BITS-1:0] vb;
	logic                   drop;

	// result with only id, direction, last, count and status set
	function automatic res_t base_res(logic [EDGE_W-1:0] id, logic rev, logic lst,
		logic [ECNT_W-1:0] cnt, status_e st);
		res_t r;
		r          = '0;
		r.edge_id  = id;
		r.reversed = rev;
		r.last     = lst;
		r.count    = cnt;
		r.status   = st;
		return r;
	endfunction

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
	assign key_lo       = lo_q;
	assign key_hi       = hi_q;
	assign drop         = elim_q && !e_rdata.right_set;

	always_comb begin
		case (k_q)
			2'd0: begin
				va = item_q.vertex_a;
				vb = item_q.vertex_b;
			end
			2'd1: begin
				va = item_q.vertex_b;
				vb = item_q.vertex_c;
			end
			default: begin
				va = item_q.vertex_c;
				vb = item_q.vertex_a;
			end
		endcase
	end

	always_comb begin
		s_port       = '0;
		e_port       = '0;
		case (state_q)
			S_CLEAR: begin
				s_port.we    = 1'b1;
				s_port.waddr = clr_q;
			end
			S_PROBE: begin
				s_port.re    = 1'b1;
				s_port.raddr = slot_q;
			end
			S_PCHK: begin
				if (s_rdata.used && s_rdata.lo == lo_q && s_rdata.hi == hi_q) begin
					e_port.re    = 1'b1;
					e_port.raddr = s_rdata.edge_id;
				end else if (!s_rdata.used && edge_cnt_q < ECNT_W'(MAX_EDGES)) begin
					s_port.we            = 1'b1;
					s_port.waddr         = slot_q;
					s_port.wdata.used    = 1'b1;
					s_port.wdata.lo      = lo_q;
					s_port.wdata.hi      = hi_q;
					s_port.wdata.edge_id = edge_cnt_q[EDGE_W-1:0];
					e_port.we            = 1'b1;
					e_port.waddr         = edge_cnt_q[EDGE_W-1:0];
					e_port.wdata.node_lo = lo_q;
					e_port.wdata.node_hi = hi_q;
					e_port.wdata.tri_l   = tri_q;
				end
			end
			S_ERD: begin
				e_port.we              = !e_rdata.right_set;
				e_port.waddr           = id_q;
				e_port.wdata           = e_rdata;
				e_port.wdata.right_set = 1'b1;
				e_port.wdata.tri_r     = tri_q;
			end
			S_FIN_RD: begin
				e_port.re    = (walk_q != edge_cnt_q);
				e_port.raddr = walk_q[EDGE_W-1:0];
			end
			S_FIN_WR: begin
				e_port.we            = 1'b1;
				e_port.waddr         = walk_q[EDGE_W-1:0];
				e_port.wdata         = e_rdata;
				e_port.wdata.dof_set = !drop;
				e_port.wdata.dof_num = drop ? '0 : dof_cnt_q[EDGE_W-1:0];
			end
			S_QRD: begin
				e_port.re    = 1'b1;
				e_port.raddr = item_q.edge_index;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			elim_q      <= 1'b1;
			tri_cnt_q   <= '0;
			edge_cnt_q  <= '0;
			clr_q       <= '0;
			slot_q      <= '0;
			probe_q     <= '0;
			walk_q      <= '0;
			dof_cnt_q   <= '0;
			k_q         <= '0;
			more_q      <= 1'b0;
			tri_q       <= '0;
			id_q        <= '0;
			rev_q       <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				elim_q <= cfg_wdata;
			end
			if (out_ch.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(KEY_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						item_q <= in_ch.data;
						more_q <= 1'b0;
						k_q    <= '0;
						case (in_ch.data.mode)
							MODE_ADD: begin
								if (tri_cnt_q >= TCNT_W'(MAX_TRIS)) begin
									res_q   <= base_res('0, 1'b0, 1'b1, edge_cnt_q, ST_FULL);
									state_q <= S_EMIT;
								end else begin
									tri_q     <= tri_cnt_q[TRI_W-1:0];
									tri_cnt_q <= tri_cnt_q + 1'b1;
									state_q   <= S_KEY;
								end
							end
							MODE_FINISH: begin
								walk_q    <= '0;
								dof_cnt_q <= '0;
								state_q   <= S_FIN_RD;
							end
							MODE_QUERY: begin
								if (ECNT_W'(in_ch.data.edge_index) >= edge_cnt_q) begin
									res_q   <= base_res(in_ch.data.edge_index, 1'b0, 1'b1,
										edge_cnt_q, ST_BAD_INDEX);
									state_q <= S_EMIT;
								end else begin
									state_q <= S_QRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_KEY: begin
					lo_q    <= (va < vb) ? va : vb;
					hi_q    <= (va < vb) ? vb : va;
					rev_q   <= !(va < vb);
					state_q <= S_HASH1;
				end
				S_HASH1: state_q <= S_HASH2;
				S_HASH2: state_q <= S_HASH3;
				S_HASH3: begin
					slot_q  <= hash;
					probe_q <= '0;
					state_q <= S_PROBE;
				end
				S_PROBE: state_q <= S_PCHK;
				S_PCHK: begin
					more_q <= (k_q != 2'd2);
					if (s_rdata.used && s_rdata.lo == lo_q && s_rdata.hi == hi_q) begin
						res_q   <= base_res(s_rdata.edge_id, rev_q, (k_q == 2'd2),
							edge_cnt_q, ST_OK);
						id_q    <= s_rdata.edge_id;
						state_q <= S_ERD;
					end else if (!s_rdata.used) begin
						if (edge_cnt_q >= ECNT_W'(MAX_EDGES)) begin
							res_q <= base_res('0, rev_q, (k_q == 2'd2), edge_cnt_q, ST_FULL);
						end else begin
							res_q      <= base_res(edge_cnt_q[EDGE_W-1:0], rev_q,
								(k_q == 2'd2), edge_cnt_q + 1'b1, ST_OK);
							edge_cnt_q <= edge_cnt_q + 1'b1;
						end
						state_q <= S_EMIT;
					end else if (probe_q == SLOT_W'(KEY_SLOTS - 1)) begin
						res_q   <= base_res('0, rev_q, (k_q == 2'd2), edge_cnt_q, ST_FULL);
						state_q <= S_EMIT;
					end else begin
						slot_q  <= slot_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_ERD: begin
					state_q <= S_EMIT;
				end
				S_FIN_RD: begin
					if (walk_q == edge_cnt_q) begin
						res_q   <= base_res('0, 1'b0, 1'b1, dof_cnt_q, ST_OK);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_FIN_WR;
					end
				end
				S_FIN_WR: begin
					if (!drop) begin
						dof_cnt_q <= dof_cnt_q + 1'b1;
					end
					walk_q  <= walk_q + 1'b1;
					state_q <= S_FIN_RD;
				end
				S_QRD: state_q <= S_QWAIT;
				S_QWAIT: begin
					res_q <= '{
						edge_id:   item_q.edge_index,
						reversed:  1'b0,
						last:      1'b1,
						node_low:  e_rdata.node_lo,
						node_high: e_rdata.node_hi,
						tri_left:  e_rdata.tri_l,
						tri_right: e_rdata.right_set ? e_rdata.tri_r : '0,
						has_right: e_rdata.right_set,
						dof_index: e_rdata.dof_set ? e_rdata.dof_num : '0,
						has_dof:   e_rdata.dof_set,
						count:     edge_cnt_q,
						status:    ST_OK
					};
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						if (more_q) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_KEY;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q <= ECNT_W'(MAX_EDGES))
		else $error("edge counter above table size");
	a_tri_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tri_cnt_q <= TCNT_W'(MAX_TRIS))
		else $error("triangle counter above table size");
	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q == $past(edge_cnt_q) || edge_cnt_q == $past(edge_cnt_q) + 1'b1)
		else $error("edge counter jumped");
	a_create_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(s_port.we && state_q != S_CLEAR) |-> (e_port.we && e_port.waddr == s_port.wdata.edge_id))
		else $error("slot insert without matching edge record write");
endmodule

/* sv/mesh_edge_numbering_core.sv */
// Top level: slot hash table RAM, edge record RAM, hash unit and sequencer.
// Depends on menc_pkg, menc_if, menc_ram, menc_hash, menc_ctrl.
//
//   channel   dir  handshake             payload
//   in_ch     in   valid/ready           mode, vertex_a..c, edge_index
//   out_ch    out  valid/ready           edge_id .. status, last on final
//   cfg       in   cfg_we (no wait)      cfg_wdata = elim_boundary
//
// Every item is accepted from in_ch, then:
// Add: per edge key order, hash, slot probes, edge record update if found, emit.
// Finish: per edge a read and write back of the edge record, then the emit.
// Query: edge record read, then emit; bad index or full triangle table: emit only.
// No new item is taken before the sequencer has emitted the last result of an item.
// After reset a clearing pass over all KEY_SLOTS (16384) slots holds in_ch.ready low.
// A stalled out_ch holds the sequencer in its emit step until the result is taken.
module mesh_edge_numbering_core import menc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	menc_in_if.sink    in_ch,
	menc_out_if.source out_ch
);
	logic [VERTEX_BITS-1:0] key_lo;
	logic [VERTEX_BITS-1:0] key_hi;
	logic [SLOT_W-1:0]      hash;
	slot_port_t             s_port;
	slot_t                  s_rdata;
	edge_port_t             e_port;
	edge_rec_t              e_rdata;

	menc_hash u_hash (
		.clk  (clk),
		.lo   (key_lo),
		.hi   (key_hi),
		.hash (hash)
	);

	menc_ram #(.W($bits(slot_t)), .DEPTH(KEY_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (s_port.we),
		.waddr (s_port.waddr),
		.wdata (s_port.wdata),
		.re    (s_port.re),
		.raddr (s_port.raddr),
		.rdata (s_rdata)
	);

	menc_ram #(.W($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_port.we),
		.waddr (e_port.waddr),
		.wdata (e_port.wdata),
		.re    (e_port.re),
		.raddr (e_port.raddr),
		.rdata (e_rdata)
	);

	menc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.key_lo    (key_lo),
		.key_hi    (key_hi),
		.hash      (hash),
		.s_port    (s_port),
		.s_rdata   (s_rdata),
		.e_port    (e_port),
		.e_rdata   (e_rdata)
	);
endmodule

/* tb/mesh_edge_numbering_core_tb.sv */
// Self-checking testbench for mesh_edge_numbering_core: directed table, then random
// triangle/finish/query traffic, then a short run without idling.
// Depends on menc_pkg and menc_if; results are checked against an in-bench edge table model.
module mesh_edge_numbering_core_tb;
	import menc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] va;
		logic [15:0] vb;
		logic [15:0] vc;
		logic [12:0] idx;
		bit          typed;
		res_t        res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	menc_in_if  in_ch();
	menc_out_if out_ch();

	mesh_edge_numbering_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// edge table model
	bit                m_elim;
	int                m_tri_cnt;
	int                m_edge_cnt;
	bit                m_slot_used [KEY_SLOTS];
	logic [31:0]       m_slot_key  [KEY_SLOTS];
	int                m_slot_edge [KEY_SLOTS];
	logic [15:0]       m_node_lo   [MAX_EDGES];
	logic [15:0]       m_node_hi   [MAX_EDGES];
	int                m_tri_l     [MAX_EDGES];
	int                m_tri_r     [MAX_EDGES];
	bit                m_right_set [MAX_EDGES];
	int                m_dof_num   [MAX_EDGES];
	bit                m_dof_set   [MAX_EDGES];

	res_t      pending_res_q[$];
	stim_row_t dir_rows[$];
	int        err_cnt;
	bit        idle_en;
	bit        hold_go;
	bit        hold_done = 1'b0;
	int        hold_left = 0;
	int        stall_left = 0;
	int        quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int find_edge(logic [15:0] a, logic [15:0] b, int tnum, output bit full);
		logic [15:0] lo, hi;
		logic [63:0] key64, prod;
		int          h, id;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		key64 = {16'd0, lo, 16'd0, hi};
		prod = key64 * HASH_MULT;
		h = int'(prod[32 +: SLOT_W]);
		full = 1'b0;
		for (int n = 0; n < KEY_SLOTS; n++) begin
			if (m_slot_used[h] && m_slot_key[h] == {lo, hi}) begin
				id = m_slot_edge[h];
				if (!m_right_set[id]) begin
					m_right_set[id] = 1'b1;
					m_tri_r[id] = tnum;
				end
				return id;
			end
			if (!m_slot_used[h]) begin
				if (m_edge_cnt >= MAX_EDGES)
					break;
				id = m_edge_cnt++;
				m_slot_used[h] = 1'b1;
				m_slot_key[h]  = {lo, hi};
				m_slot_edge[h] = id;
				m_node_lo[id]  = lo;
				m_node_hi[id]  = hi;
				m_tri_l[id]    = tnum;
				m_tri_r[id]    = 0;
				m_right_set[id] = 1'b0;
				m_dof_num[id]  = 0;
				m_dof_set[id]  = 1'b0;
				return id;
			end
			h = (h + 1) % KEY_SLOTS;
		end
		full = 1'b1;
		return 0;
	endfunction

	function automatic void predict_results(in_item_t it, ref res_t outs[$]);
		res_t        r;
		logic [15:0] vert [3];
		logic [15:0] a, b;
		int          tnum, id, cnt;
		bit          full;
		r = '0;
		case (it.mode)
			MODE_ADD: begin
				if (m_tri_cnt >= MAX_TRIS) begin
					r.last = 1'b1;
					r.count = 14'(m_edge_cnt);
					r.status = ST_FULL;
					outs.insert(outs.size(), r);
				end else begin
					vert[0] = it.vertex_a;
					vert[1] = it.vertex_b;
					vert[2] = it.vertex_c;
					tnum = m_tri_cnt++;
					for (int k = 0; k < 3; k++) begin
						a = vert[k];
						b = vert[(k + 1) % 3];
						id = find_edge(a, b, tnum, full);
						r = '0;
						r.edge_id = 13'(id);
						r.reversed = !(a < b);
						r.last = (k == 2);
						r.count = 14'(m_edge_cnt);
						r.status = full ? ST_FULL : ST_OK;
						outs.insert(outs.size(), r);
					end
				end
			end
			MODE_FINISH: begin
				cnt = 0;
				for (int i = 0; i < m_edge_cnt; i++) begin
					if (m_elim && !m_right_set[i]) begin
						m_dof_set[i] = 1'b0;
						m_dof_num[i] = 0;
					end else begin
						m_dof_set[i] = 1'b1;
						m_dof_num[i] = cnt++;
					end
				end
				r.last = 1'b1;
				r.count = 14'(cnt);
				outs.insert(outs.size(), r);
			end
			MODE_QUERY: begin
				r.edge_id = it.edge_index;
				r.last = 1'b1;
				r.count = 14'(m_edge_cnt);
				if (int'(it.edge_index) >= m_edge_cnt) begin
					r.status = ST_BAD_INDEX;
				end else begin
					id = int'(it.edge_index);
					r.node_low  = m_node_lo[id];
					r.node_high = m_node_hi[id];
					r.tri_left  = 12'(m_tri_l[id]);
					r.tri_right = m_right_set[id] ? 12'(m_tri_r[id]) : 12'd0;
					r.has_right = m_right_set[id];
					r.dof_index = m_dof_set[id] ? 13'(m_dof_num[id]) : 13'd0;
					r.has_dof   = m_dof_set[id];
				end
				outs.insert(outs.size(), r);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
		err_cnt++;
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (pending_res_q.size() == 0) begin
			report_mismatch("unexpected transaction, edge_id", got.edge_id, -1);
			return;
		end
		want = pending_res_q.pop_front();
		if (got.edge_id !== want.edge_id)     report_mismatch("edge_id", got.edge_id, want.edge_id);
		if (got.reversed !== want.reversed)   report_mismatch("reversed", got.reversed, want.reversed);
		if (got.last !== want.last)           report_mismatch("last", got.last, want.last);
		if (got.node_low !== want.node_low)   report_mismatch("node_low", got.node_low, want.node_low);
		if (got.node_high !== want.node_high) report_mismatch("node_high", got.node_high, want.node_high);
		if (got.tri_left !== want.tri_left)   report_mismatch("tri_left", got.tri_left, want.tri_left);
		if (got.tri_right !== want.tri_right) report_mismatch("tri_right", got.tri_right, want.tri_right);
		if (got.has_right !== want.has_right) report_mismatch("has_right", got.has_right, want.has_right);
		if (got.dof_index !== want.dof_index) report_mismatch("dof_index", got.dof_index, want.dof_index);
		if (got.has_dof !== want.has_dof)     report_mismatch("has_dof", got.has_dof, want.has_dof);
		if (got.count !== want.count)         report_mismatch("count", got.count, want.count);
		if (got.status !== want.status)       report_mismatch("status", got.status, want.status);
	endtask

	// result sink with random stalls and one long hold-off
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			check_result(out_ch.data);
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_en && arst_n && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL mesh_edge_numbering_core");
			$finish;
		end
	end

	task automatic send_item(in_item_t it);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_res_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_elim(bit v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_elim = v;
	endtask

	function automatic void add_row(logic [1:0] mode, logic [15:0] va, logic [15:0] vb,
		logic [15:0] vc, logic [12:0] idx);
		stim_row_t row;
		row = '{mode, va, vb, vc, idx, 1'b0, '0};
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic void typed_row(logic [1:0] mode, logic [12:0] idx, res_t res);
		stim_row_t row;
		row = '{mode, 16'd0, 16'd0, 16'd0, idx, 1'b1, res};
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic res_t mk_res(logic [12:0] id, logic [13:0] cnt, status_e st);
		res_t r;
		r = '0;
		r.edge_id = id;
		r.last = 1'b1;
		r.count = cnt;
		r.status = st;
		return r;
	endfunction

	function automatic logic [15:0] pick_vertex();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		it = '0;
		r = $urandom_range(0, 99);
		it.vertex_a = pick_vertex();
		it.vertex_b = pick_vertex();
		it.vertex_c = pick_vertex();
		it.edge_index = 13'($urandom);
		if (r < 68) begin
			it.mode = MODE_ADD;
		end else if (r < 76) begin
			it.mode = MODE_FINISH;
		end else if (r < 95) begin
			it.mode = MODE_QUERY;
			if (m_edge_cnt > 0 && $urandom_range(0, 9) < 8)
				it.edge_index = 13'($urandom_range(0, m_edge_cnt - 1));
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	task automatic run_item(in_item_t it, bit typed, res_t res);
		res_t outs[$];
		send_item(it);
		predict_results(it, outs);
		if (typed)
			pending_res_q.insert(pending_res_q.size(), res);
		else
			foreach (outs[i]) pending_res_q.insert(pending_res_q.size(), outs[i]);
	endtask

	initial begin
		in_item_t it;
		int       done;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		err_cnt = 0;
		idle_en = 1'b1;
		hold_go = 1'b0;
		m_elim = 1'b1;
		m_tri_cnt = 0;
		m_edge_cnt = 0;
		foreach (m_slot_used[i]) m_slot_used[i] = 1'b0;

		typed_row(MODE_QUERY, 13'd0, mk_res(13'd0, 14'd0, ST_BAD_INDEX));
		typed_row(MODE_FINISH, 13'd0, mk_res(13'd0, 14'd0, ST_OK));
		add_row(MODE_ADD, 16'd0, 16'd1, 16'd2, 13'd0);
		add_row(MODE_ADD, 16'd2, 16'd1, 16'd3, 13'd0);
		add_row(MODE_ADD, 16'hFFFF, 16'hFFFF, 16'd0, 13'd0);
		add_row(MODE_ADD, 16'd0, 16'hFFFF, 16'd1, 13'd0);
		add_row(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
		typed_row(MODE_QUERY, 13'h1FFF, mk_res(13'h1FFF, 14'd8, ST_BAD_INDEX));
		typed_row(MODE_QUERY, 13'd8, mk_res(13'd8, 14'd8, ST_BAD_INDEX));
		add_row(MODE_FINISH, 16'd0, 16'd0, 16'd0, 13'd0);
		for (int i = 0; i < 8; i++)
			add_row(MODE_QUERY, 16'd0, 16'd0, 16'd0, 13'(i));
		add_row(MODE_ADD, 16'd3, 16'd3, 16'd3, 13'd0);
		add_row(MODE_QUERY, 16'd0, 16'd0, 16'd0, 13'd8);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_elim(1'b1);

		foreach (dir_rows[i]) begin
			it = '0;
			it.mode = dir_rows[i].mode;
			it.vertex_a = dir_rows[i].va;
			it.vertex_b = dir_rows[i].vb;
			it.vertex_c = dir_rows[i].vc;
			it.edge_index = dir_rows[i].idx;
			run_item(it, dir_rows[i].typed, dir_rows[i].res);
		end
		drain_results();

		write_elim(1'b0);
		it = '0;
		it.mode = MODE_FINISH;
		run_item(it, 1'b0, '0);
		it.mode = MODE_QUERY;
		it.edge_index = 13'd5;
		run_item(it, 1'b0, '0);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			write_elim(ph[0]);
			done = 0;
			while (done < 32) begin
				if (ph == 1 && done == 5)
					hold_go <= 1'b1;
				it = random_item();
				if (it.mode != MODE_UNUSED)
					done++;
				run_item(it, 1'b0, '0);
			end
			it = '0;
			it.mode = MODE_FINISH;
			run_item(it, 1'b0, '0);
			drain_results();
		end

		// closing run without idling
		idle_en = 1'b0;
		write_elim(1'b1);
		for (int i = 0; i < 6; i++) begin
			it = random_item();
			run_item(it, 1'b0, '0);
		end
		it = '0;
		it.mode = MODE_FINISH;
		run_item(it, 1'b0, '0);
		it.mode = MODE_QUERY;
		it.edge_index = 13'h1FFF;
		run_item(it, 1'b0, '0);
		it.edge_index = 13'd0;
		run_item(it, 1'b0, '0);
		drain_results();

		if (err_cnt == 0)
			$display("PASS mesh_edge_numbering_core");
		else
			$display("FAIL mesh_edge_numbering_core");
		$finish;
	end

endmodule
